### rtl/lpas_pkg.sv
`timescale 1ns / 1ps

package lpas_pkg;

	localparam int CoordW = 11;
	localparam int ErrW   = CoordW + 3;
	localparam int AddrW  = 32;
	localparam int ColorW = 32;
	localparam int PitchW = 16;
	localparam int PaddrW = 3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// register select is paddr[2]
	localparam logic REG_FRAME_BASE = 1'b0;
	localparam logic REG_ROW_PITCH  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CoordW-1:0] start_x;
		logic [CoordW-1:0] start_y;
		logic [CoordW-1:0] end_x;
		logic [CoordW-1:0] end_y;
		logic [ColorW-1:0] line_color;
	} cmd_t;

	typedef struct packed {
		logic [AddrW-1:0]  pixel_addr;
		logic [ColorW-1:0] pixel_color;
		logic [CoordW-1:0] pixel_x;
		logic [CoordW-1:0] pixel_y;
		logic              last_pixel;
	} pix_t;

	typedef struct packed {
		logic                   busy;
		logic [AddrW-1:0]       cur_addr;
		logic [CoordW-1:0]      cur_x;
		logic [CoordW-1:0]      cur_y;
		logic signed [ErrW-1:0] err_term;
		logic [CoordW-1:0]      pixels_left;
		logic [CoordW-1:0]      major_delta;
		logic [CoordW-1:0]      minor_delta;
		logic                   x_major;
		logic                   x_negative;
		logic                   y_negative;
		logic [ColorW-1:0]      held_color;
	} line_t;

endpackage

### rtl/lpas_setup.sv
`timescale 1ns / 1ps

module lpas_setup import lpas_pkg::*; (
	input  cmd_t              cmd,
	input  logic [AddrW-1:0]  frame_base,
	input  logic [PitchW-1:0] row_pitch,
	output line_t             line
);

	logic                      x_neg, y_neg, x_maj;
	logic [CoordW-1:0]         dx, dy, major, minor;
	logic [CoordW+PitchW-1:0]  row_off;

	always_comb begin
		x_neg = cmd.end_x < cmd.start_x;
		y_neg = cmd.end_y < cmd.start_y;
		dx = x_neg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
		dy = y_neg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
		// ties and single points go y-major
		x_maj = dx > dy;
		major = x_maj ? dx : dy;
		minor = x_maj ? dy : dx;
		row_off = (CoordW+PitchW)'(cmd.start_y) * (CoordW+PitchW)'(row_pitch);

		line.busy        = 1'b1;
		line.cur_addr    = frame_base + AddrW'({cmd.start_x, 2'b00}) + AddrW'(row_off);
		line.cur_x       = cmd.start_x;
		line.cur_y       = cmd.start_y;
		line.err_term    = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		line.pixels_left = major;
		line.major_delta = major;
		line.minor_delta = minor;
		line.x_major     = x_maj;
		line.x_negative  = x_neg;
		line.y_negative  = y_neg;
		line.held_color  = cmd.line_color;
	end

endmodule

### rtl/lpas_step.sv
`timescale 1ns / 1ps

module lpas_step import lpas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cmd_t              cmd,
	input  line_t             setup,
	input  logic [PitchW-1:0] row_pitch,
	output logic              res_valid,
	output pix_t              res
);

	line_t                  line_q;
	line_t                  line_nxt;
	logic                   last;
	logic                   diag;
	logic                   mv_x, mv_y;
	logic [AddrW-1:0]       x_off, y_off;
	logic signed [ErrW-1:0] err_dec;

	always_comb begin
		last = line_q.pixels_left == '0;
		res_valid = accept && cmd.op == OP_STEP && line_q.busy;
		res.pixel_addr  = line_q.cur_addr;
		res.pixel_color = line_q.held_color;
		res.pixel_x     = line_q.cur_x;
		res.pixel_y     = line_q.cur_y;
		res.last_pixel  = last;

		// error term >= 0 means a diagonal step this time
		diag = !line_q.err_term[ErrW-1];
		mv_x = line_q.x_major || diag;
		mv_y = !line_q.x_major || diag;
		x_off = '0;
		if (mv_x) begin
			x_off = line_q.x_negative ? -AddrW'(4) : AddrW'(4);
		end
		y_off = '0;
		if (mv_y) begin
			y_off = line_q.y_negative ? -AddrW'(row_pitch) : AddrW'(row_pitch);
		end
		err_dec = diag ? $signed({2'b00, line_q.major_delta, 1'b0}) : '0;

		line_nxt = line_q;
		line_nxt.cur_addr = line_q.cur_addr + x_off + y_off;
		if (mv_x) begin
			line_nxt.cur_x = line_q.x_negative ? line_q.cur_x - CoordW'(1)
				: line_q.cur_x + CoordW'(1);
		end
		if (mv_y) begin
			line_nxt.cur_y = line_q.y_negative ? line_q.cur_y - CoordW'(1)
				: line_q.cur_y + CoordW'(1);
		end
		line_nxt.err_term = line_q.err_term - err_dec
			+ $signed({2'b00, line_q.minor_delta, 1'b0});
		line_nxt.pixels_left = line_q.pixels_left - CoordW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (accept) begin
			if (cmd.op == OP_START) begin
				line_q <= setup;
			end else if (line_q.busy) begin
				if (last) begin
					line_q.busy <= 1'b0;
				end else begin
					line_q <= line_nxt;
				end
			end
		end
	end

endmodule

### rtl/lpas_out_buf.sv
`timescale 1ns / 1ps

module lpas_out_buf import lpas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  pix_t res,
	output logic full,
	output logic pix_valid,
	input  logic pix_stall,
	output pix_t pix
);

	logic main_valid_q, skid_valid_q;
	pix_t main_q, skid_q;

	assign full      = skid_valid_q;
	assign pix_valid = main_valid_q;
	assign pix       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || !pix_stall) begin
			// no new result can arrive while the skid slot is full
			main_valid_q <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || !pix_stall) begin
			main_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule

### rtl/line_pixel_address_stepper_top.sv
// channel | dir | handshake               | payload
// cmd     | in  | cmd_valid / cmd_stall   | cmd_t (op, endpoints, color)
// pix     | out | pix_valid / pix_stall   | pix_t (address, color, x, y, last)
// apb     | in  | psel / penable / pready | frame_base, row_pitch
//
// One item per clock while cmd_stall is low: a start item loads the line
// state when taken; a step item's pixel is registered in the output buffer.
// The start address (one 11x16 multiply plus adds) sets the longest path.
// Reset clears the line state, so step items give nothing until a start.
// Output register plus one skid entry: cmd_stall is high while the skid entry
// holds a pixel, from the cycle after a pixel meets a stalled, full output.
`timescale 1ns / 1ps

module line_pixel_address_stepper_top import lpas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              pix_valid,
	input  logic              pix_stall,
	output pix_t              pix,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [AddrW-1:0]  frame_base_q;
	logic [PitchW-1:0] row_pitch_q;
	logic              accept;
	logic              buf_full;
	logic              res_valid;
	pix_t              res;
	line_t             setup;

	assign pready    = 1'b1;
	assign cmd_stall = buf_full;
	assign accept    = cmd_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			row_pitch_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FRAME_BASE: frame_base_q <= pwdata;
				REG_ROW_PITCH:  row_pitch_q  <= pwdata[PitchW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_BASE: prdata = frame_base_q;
			REG_ROW_PITCH:  prdata = 32'(row_pitch_q);
			default:        prdata = '0;
		endcase
	end

	lpas_setup u_setup (
		.cmd        (cmd),
		.frame_base (frame_base_q),
		.row_pitch  (row_pitch_q),
		.line       (setup)
	);

	lpas_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.setup     (setup),
		.row_pitch (row_pitch_q),
		.res_valid (res_valid),
		.res       (res)
	);

	lpas_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.full      (buf_full),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule

### verif/line_pixel_address_stepper_top_test.sv
`timescale 1ns / 1ps

module line_pixel_address_stepper_top_test;
	import lpas_pkg::*;

	localparam int CoordMax = (1 << CoordW) - 1;
	localparam int HoldCycles = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cmd_t              cmd = '0;
	logic              pix_valid;
	logic              pix_stall = 1'b0;
	pix_t              pix;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PaddrW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// line engine state as the block should hold it
	line_t       line_st = '0;
	logic [31:0] frame_base_q = '0;
	logic [15:0] row_pitch_q = '0;
	pix_t        pixels_due[$];

	int mismatches = 0;
	int lines_started = 0;
	int pixels_checked = 0;
	int useful_items = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;

	line_pixel_address_stepper_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void walk_x();
		if (line_st.x_negative) begin
			line_st.cur_x = line_st.cur_x - CoordW'(1);
			line_st.cur_addr = line_st.cur_addr - 32'd4;
		end else begin
			line_st.cur_x = line_st.cur_x + CoordW'(1);
			line_st.cur_addr = line_st.cur_addr + 32'd4;
		end
	endfunction

	function automatic void walk_y();
		if (line_st.y_negative) begin
			line_st.cur_y = line_st.cur_y - CoordW'(1);
			line_st.cur_addr = line_st.cur_addr - 32'(row_pitch_q);
		end else begin
			line_st.cur_y = line_st.cur_y + CoordW'(1);
			line_st.cur_addr = line_st.cur_addr + 32'(row_pitch_q);
		end
	endfunction

	// Bresenham engine: a start loads the line, a step emits the current pixel
	function automatic void apply_cmd(cmd_t c);
		int dx, dy, err;
		pix_t p;
		if (c.op == OP_START) begin
			lines_started++;
			useful_items++;
			line_st.busy = 1'b1;
			line_st.held_color = c.line_color;
			line_st.cur_x = c.start_x;
			line_st.cur_y = c.start_y;
			line_st.cur_addr = frame_base_q + 32'(c.start_x) * 32'd4
				+ 32'(c.start_y) * 32'(row_pitch_q);
			line_st.x_negative = c.end_x < c.start_x;
			line_st.y_negative = c.end_y < c.start_y;
			dx = line_st.x_negative ? int'(c.start_x) - int'(c.end_x)
				: int'(c.end_x) - int'(c.start_x);
			dy = line_st.y_negative ? int'(c.start_y) - int'(c.end_y)
				: int'(c.end_y) - int'(c.start_y);
			// ties and single points walk along y
			line_st.x_major = dx > dy;
			line_st.major_delta = CoordW'(line_st.x_major ? dx : dy);
			line_st.minor_delta = CoordW'(line_st.x_major ? dy : dx);
			line_st.err_term = ErrW'(2 * int'(line_st.minor_delta)
				- int'(line_st.major_delta));
			line_st.pixels_left = line_st.major_delta;
		end else if (line_st.busy) begin
			useful_items++;
			p.pixel_addr = line_st.cur_addr;
			p.pixel_color = line_st.held_color;
			p.pixel_x = line_st.cur_x;
			p.pixel_y = line_st.cur_y;
			p.last_pixel = (line_st.pixels_left == '0);
			pixels_due.push_back(p);
			if (p.last_pixel) begin
				line_st.busy = 1'b0;
			end else begin
				err = int'(line_st.err_term);
				if (err >= 0) begin
					err -= 2 * int'(line_st.major_delta);
					if (line_st.x_major) walk_y();
					else walk_x();
				end
				err += 2 * int'(line_st.minor_delta);
				line_st.err_term = ErrW'(err);
				if (line_st.x_major) walk_x();
				else walk_y();
				line_st.pixels_left = line_st.pixels_left - CoordW'(1);
			end
		end
	endfunction

	function automatic cmd_t rand_cmd();
		logic [95:0] bits_r;
		bits_r = {$urandom, $urandom, $urandom};
		return bits_r[$bits(cmd_t)-1:0];
	endfunction

	function automatic int near_coord(int origin, int span);
		int lo, hi;
		lo = (origin - span < 0) ? 0 : origin - span;
		hi = (origin + span > CoordMax) ? CoordMax : origin + span;
		return $urandom_range(hi, lo);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// receiver: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_taken) begin
			hold_taken <= hold_req;
			hold_left <= HoldCycles;
			pix_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				$display("%0t: pixel expected none actual addr %h x %0d y %0d", $time,
					pix.pixel_addr, pix.pixel_x, pix.pixel_y);
			end else begin
				want = pixels_due.pop_front();
				pixels_checked++;
				check_field("pixel_addr", want.pixel_addr, pix.pixel_addr);
				check_field("pixel_color", want.pixel_color, pix.pixel_color);
				check_field("pixel_x", 32'(want.pixel_x), 32'(pix.pixel_x));
				check_field("pixel_y", 32'(want.pixel_y), 32'(pix.pixel_y));
				check_field("last_pixel", 32'(want.last_pixel), 32'(pix.last_pixel));
			end
		end
	end

	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			cmd <= rand_cmd();
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		apply_cmd(c);
	endtask

	task automatic send_line(int x0, int y0, int x1, int y1, logic [31:0] color, int steps);
		cmd_t c;
		c = rand_cmd();
		c.op = OP_START;
		c.start_x = CoordW'(x0);
		c.start_y = CoordW'(y0);
		c.end_x = CoordW'(x1);
		c.end_y = CoordW'(y1);
		c.line_color = color;
		send_cmd(c);
		repeat (steps) begin
			c = rand_cmd();
			c.op = OP_STEP;
			send_cmd(c);
		end
	endtask

	task automatic send_rand_line();
		int x0, y0, x1, y1, span, adx, ady, major, steps;
		span = ($urandom_range(24, 0) == 0) ? 250 : 12;
		x0 = $urandom_range(CoordMax, 0);
		y0 = $urandom_range(CoordMax, 0);
		x1 = near_coord(x0, span);
		y1 = near_coord(y0, span);
		adx = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady = (y1 > y0) ? y1 - y0 : y0 - y1;
		major = (adx > ady) ? adx : ady;
		case ($urandom_range(9, 0))
			0: steps = $urandom_range(major, 0);             // dropped by the next start
			1: steps = major + 1 + $urandom_range(3, 1);     // trailing steps while idle
			default: steps = major + 1;
		endcase
		send_line(x0, y0, x1, y1, $urandom, steps);
	endtask

	task automatic drain_pixels();
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_ROW_PITCH) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PaddrW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_ROW_PITCH) row_pitch_q = value[15:0];
		else frame_base_q = value;
		// read back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", value & mask, prdata & mask);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] base, logic [15:0] pitch);
		drain_pixels();
		write_reg(REG_FRAME_BASE, base);
		write_reg(REG_ROW_PITCH, {16'h0, pitch});
	endtask

	// registers still at reset: a step with no line, then a short line
	task automatic test_idle_steps();
		cmd_t c;
		send_idle_pct = 16;
		stall_pct = 57;
		c = rand_cmd();
		c.op = OP_STEP;
		send_cmd(c);
		send_line(2, 1, 4, 2, 32'h1234_5678, 3);
	endtask

	task automatic test_directed_lines();
		set_config(32'hFFFF_FFF0, 16'h2000);
		send_line(CoordMax, CoordMax, CoordMax, CoordMax, 32'h0, 2);
		send_line(0, 0, 2, 2, 32'hFFFF_FFFF, 3);
		send_line(CoordMax, 0, CoordMax - 2, 0, 32'hA5A5_5A5A, 3);
		send_line(7, CoordMax, 6, CoordMax - 3, 32'h5A5A_A5A5, 4);
		// restart while a line is still running
		send_line(0, 0, CoordMax, CoordMax, 32'h0F0F_0F0F, 2);
		send_line(CoordMax, CoordMax, 0, 0, 32'hF0F0_F0F0, 1);
	endtask

	// output held off long enough that the block backs up into cmd
	task automatic test_backpressure();
		drain_pixels();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req++;
		send_line(0, 0, 59, 10, 32'hC0DE_CAFE, 60);
	endtask

	task automatic test_random_lines(int idle_pct, int hold_pct, logic [31:0] base,
		logic [15:0] pitch, int target);
		int goal;
		set_config(base, pitch);
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		goal = useful_items + target;
		while (useful_items < goal) send_rand_line();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_steps();
		test_directed_lines();
		test_backpressure();
		test_random_lines(16, 57, $urandom, 16'($urandom), 460);
		test_random_lines(57, 16, 32'hFFFF_FFFF, 16'h0000, 460);
		test_random_lines(0, 0, 32'h0000_0000, 16'hFFFF, 460);
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d line starts and %0d checked pixel writes", lines_started,
			pixels_checked);
		$display("across five register settings, idle and stall mixes and a long output hold");
		if (mismatches == 0 && pixels_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Timed out with %0d pixels outstanding", pixels_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
